### hdl/hrbp_pkg.sv
// hrbp_pkg: shared types and constants of the http request byte parser
// byte classes passed from the front to the back, result kind codes, header name table
// no dependencies
`default_nettype none

package hrbp_pkg;

  // field kind codes of a result
  typedef enum logic [2:0] {
    KIND_METHOD  = 3'd0,
    KIND_URI     = 3'd1,
    KIND_VERSION = 3'd2,
    KIND_NAME    = 3'd3,
    KIND_VALUE   = 3'd4,
    KIND_BODY    = 3'd5,
    KIND_DELIM   = 3'd6
  } kind_e;

  // characters the framing looks for
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_COLON = 8'h3a;
  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_VT    = 8'h0b;
  localparam logic [7:0] CHR_FF    = 8'h0c;
  localparam logic [7:0] CHR_PLUS  = 8'h2b;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  // length of the header name "Content-Length"
  localparam logic [3:0] NAME_LEN = 4'd14;

  // one classified input byte, as it sits in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       is_space;
    logic       is_colon;
    logic       is_cr;
    logic       is_lf;
    logic       is_ws;
    logic       is_plus;
    logic       is_minus;
    logic       is_digit;
    logic [3:0] digit;
  } cls_t;

  // characters of "Content-Length" by position
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] chr;
    case (idx)
      4'd0:    chr = 8'h43; // C
      4'd1:    chr = 8'h6f; // o
      4'd2:    chr = 8'h6e; // n
      4'd3:    chr = 8'h74; // t
      4'd4:    chr = 8'h65; // e
      4'd5:    chr = 8'h6e; // n
      4'd6:    chr = 8'h74; // t
      4'd7:    chr = 8'h2d; // -
      4'd8:    chr = 8'h4c; // L
      4'd9:    chr = 8'h65; // e
      4'd10:   chr = 8'h6e; // n
      4'd11:   chr = 8'h67; // g
      4'd12:   chr = 8'h74; // t
      4'd13:   chr = 8'h68; // h
      default: chr = 8'h00;
    endcase
    return chr;
  endfunction

endpackage

`default_nettype wire

### hdl/hrbp_front.sv
// hrbp_front: input side of the parser, accepts bytes and classifies them
// pushes one cls_t per accepted byte into the queue; uses hrbp_pkg
`default_nettype none

module hrbp_front
  import hrbp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,
  input  wire logic [0:0] s_axis_tuser_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output cls_t            q_wdata_o
);

  logic [7:0] chr;

  assign chr             = s_axis_tdata_i;
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    q_wdata_o.data     = chr;
    q_wdata_o.restart  = s_axis_tuser_i[0];
    q_wdata_o.is_space = (chr == CHR_SPACE);
    q_wdata_o.is_colon = (chr == CHR_COLON);
    q_wdata_o.is_cr    = (chr == CHR_CR);
    q_wdata_o.is_lf    = (chr == CHR_LF);
    q_wdata_o.is_ws    = (chr == CHR_SPACE) || (chr == CHR_TAB) || (chr == CHR_LF) ||
                         (chr == CHR_VT) || (chr == CHR_FF) || (chr == CHR_CR);
    q_wdata_o.is_plus  = (chr == CHR_PLUS);
    q_wdata_o.is_minus = (chr == CHR_MINUS);
    q_wdata_o.is_digit = (chr >= CHR_ZERO) && (chr <= CHR_NINE);
    q_wdata_o.digit    = 4'(chr - CHR_ZERO);
  end

  // a push never happens while the queue is full
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_full_i)
    else $error("push into full queue");

endmodule

`default_nettype wire

### hdl/hrbp_queue.sv
// hrbp_queue: two-entry queue of classified bytes between front and back
// uses hrbp_pkg for cls_t
`default_nettype none

module hrbp_queue
  import hrbp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cls_t      wdata_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cls_t      rdata_o,
  output logic      not_empty_o
);

  cls_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == 2'd2);
  assign not_empty_o = (cnt_q != 2'd0);
  assign rdata_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> not_empty_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

### hdl/hrbp_back.sv
// hrbp_back: parser state machine, content-length conversion and body counter
// takes classified bytes from the queue, holds the result in an output register; uses hrbp_pkg
`default_nettype none

module hrbp_back
  import hrbp_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_not_empty_i,
  input  cls_t             q_rdata_i,
  output logic             q_pop_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,
  output logic [2:0]       m_axis_tuser_o
);

  localparam int unsigned W = LENGTH_WIDTH;

  typedef enum logic [11:0] {
    PH_METHOD  = 12'b0000_0000_0001,
    PH_URI     = 12'b0000_0000_0010,
    PH_VERSION = 12'b0000_0000_0100,
    PH_LINE_LF = 12'b0000_0000_1000,
    PH_NAME    = 12'b0000_0001_0000,
    PH_SPACE   = 12'b0000_0010_0000,
    PH_VALUE   = 12'b0000_0100_0000,
    PH_PAIR_LF = 12'b0000_1000_0000,
    PH_HDRS_LF = 12'b0001_0000_0000,
    PH_BODY    = 12'b0010_0000_0000,
    PH_DONE    = 12'b0100_0000_0000,
    PH_ERROR   = 12'b1000_0000_0000
  } phase_e;

  typedef enum logic [3:0] {
    AT_SKIP   = 4'b0001,
    AT_SIGN   = 4'b0010,
    AT_DIGITS = 4'b0100,
    AT_STOP   = 4'b1000
  } atoi_e;

  // parser state
  phase_e       ph_q, ph_d, ph_c;
  logic [3:0]   idx_q, idx_d, idx_c;
  logic         mis_q, mis_d, mis_c;
  logic [W-1:0] acc_q, acc_d, acc_c;
  atoi_e        at_q, at_d, at_c;
  logic         neg_q, neg_d, neg_c;
  logic         seen_q, seen_d, seen_c;
  logic [W-1:0] blen_q, blen_d, blen_c;
  logic [W-1:0] bcnt_q, bcnt_d, bcnt_c;
  logic         err_q, err_d, err_c;

  // output register
  logic         ovld_q;
  logic [7:0]   obyte_q;
  kind_e        okind_q;
  logic         opair_q, olen_q, oerr_q, odone_q;
  logic [31:0]  ocl_q;

  kind_e        kind;
  logic         pair, is_len;
  logic         take;
  logic [W+3:0] acc_ext, acc_x10;
  logic         acc_ovf;
  logic         cl_sat;
  logic [31:0]  cl;
  logic [7:0]   chr;

  assign take    = q_not_empty_i && (!ovld_q || m_axis_tready_i);
  assign q_pop_o = take;
  assign chr     = q_rdata_i.data;

  // restart clears the state before this byte is handled
  always_comb begin
    if (q_rdata_i.restart) begin
      ph_c   = PH_METHOD;
      idx_c  = 4'd0;
      mis_c  = 1'b0;
      acc_c  = '0;
      at_c   = AT_SKIP;
      neg_c  = 1'b0;
      seen_c = 1'b0;
      blen_c = '0;
      bcnt_c = '0;
      err_c  = 1'b0;
    end else begin
      ph_c   = ph_q;
      idx_c  = idx_q;
      mis_c  = mis_q;
      acc_c  = acc_q;
      at_c   = at_q;
      neg_c  = neg_q;
      seen_c = seen_q;
      blen_c = blen_q;
      bcnt_c = bcnt_q;
      err_c  = err_q;
    end
  end

  // acc * 10 + digit, overflow when any bit above the length width is set
  always_comb begin
    acc_ext = {4'd0, acc_c};
    acc_x10 = (acc_ext << 3) + (acc_ext << 1) + {{W{1'b0}}, q_rdata_i.digit};
    acc_ovf = |acc_x10[W+3:W];
  end

  always_comb begin
    ph_d   = ph_c;
    idx_d  = idx_c;
    mis_d  = mis_c;
    acc_d  = acc_c;
    at_d   = at_c;
    neg_d  = neg_c;
    seen_d = seen_c;
    blen_d = blen_c;
    bcnt_d = bcnt_c;
    err_d  = err_c;
    kind   = KIND_DELIM;
    pair   = 1'b0;
    is_len = 1'b0;
    case (ph_c)
      PH_METHOD: begin
        if (q_rdata_i.is_space) ph_d = PH_URI;
        else kind = KIND_METHOD;
      end
      PH_URI: begin
        if (q_rdata_i.is_space) ph_d = PH_VERSION;
        else kind = KIND_URI;
      end
      PH_VERSION: begin
        if (q_rdata_i.is_cr) ph_d = PH_LINE_LF;
        else kind = KIND_VERSION;
      end
      PH_LINE_LF: begin
        if (q_rdata_i.is_lf) begin
          ph_d = PH_NAME;
        end else begin
          ph_d  = PH_ERROR;
          err_d = 1'b1;
        end
      end
      PH_NAME: begin
        if (q_rdata_i.is_colon) begin
          ph_d = PH_SPACE;
        end else if (q_rdata_i.is_cr) begin
          ph_d = PH_HDRS_LF;
        end else begin
          kind = KIND_NAME;
          // exact, case-sensitive compare one position per byte
          if (mis_c || (idx_c >= NAME_LEN)) mis_d = 1'b1;
          else if (name_char(idx_c) == chr) idx_d = idx_c + 4'd1;
          else mis_d = 1'b1;
        end
      end
      PH_SPACE: begin
        if (q_rdata_i.is_space) begin
          ph_d = PH_VALUE;
        end else begin
          ph_d  = PH_ERROR;
          err_d = 1'b1;
        end
      end
      PH_VALUE: begin
        if (q_rdata_i.is_cr) begin
          ph_d = PH_PAIR_LF;
        end else begin
          kind = KIND_VALUE;
          if (at_c == AT_STOP) begin
            at_d = AT_STOP;
          end else if ((at_c == AT_SKIP) && q_rdata_i.is_ws) begin
            at_d = AT_SKIP;
          end else if ((at_c == AT_SKIP) && (q_rdata_i.is_plus || q_rdata_i.is_minus)) begin
            neg_d = q_rdata_i.is_minus;
            at_d  = AT_SIGN;
          end else if (q_rdata_i.is_digit) begin
            acc_d = acc_ovf ? {W{1'b1}} : acc_x10[W-1:0];
            at_d  = AT_DIGITS;
          end else begin
            at_d = AT_STOP;
          end
        end
      end
      PH_PAIR_LF: begin
        if (!q_rdata_i.is_lf) begin
          ph_d  = PH_ERROR;
          err_d = 1'b1;
        end else begin
          pair = 1'b1;
          if (!mis_c && (idx_c == NAME_LEN)) begin
            is_len = 1'b1;
            seen_d = 1'b1;
            blen_d = (neg_c && (acc_c != '0)) ? {W{1'b1}} : acc_c;
          end
          idx_d = 4'd0;
          mis_d = 1'b0;
          acc_d = '0;
          at_d  = AT_SKIP;
          neg_d = 1'b0;
          ph_d  = PH_NAME;
        end
      end
      PH_HDRS_LF: begin
        if (!q_rdata_i.is_lf) begin
          ph_d  = PH_ERROR;
          err_d = 1'b1;
        end else begin
          bcnt_d = '0;
          ph_d   = (seen_c && (blen_c != '0)) ? PH_BODY : PH_DONE;
        end
      end
      PH_BODY: begin
        kind   = KIND_BODY;
        bcnt_d = bcnt_c + W'(1);
        if (bcnt_d == blen_c) ph_d = PH_DONE;
      end
      default: begin
      end
    endcase
  end

  // length shown on 32 bits, saturated when the length width is wider
  always_comb begin
    cl_sat = (W > 32) && (|(blen_d >> 32));
    cl     = cl_sat ? 32'hffff_ffff : 32'(blen_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_METHOD;
      idx_q  <= 4'd0;
      mis_q  <= 1'b0;
      acc_q  <= '0;
      at_q   <= AT_SKIP;
      neg_q  <= 1'b0;
      seen_q <= 1'b0;
      blen_q <= '0;
      bcnt_q <= '0;
      err_q  <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      if (take) begin
        ph_q   <= ph_d;
        idx_q  <= idx_d;
        mis_q  <= mis_d;
        acc_q  <= acc_d;
        at_q   <= at_d;
        neg_q  <= neg_d;
        seen_q <= seen_d;
        blen_q <= blen_d;
        bcnt_q <= bcnt_d;
        err_q  <= err_d;
      end
      if (take) ovld_q <= 1'b1;
      else if (m_axis_tready_i) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      obyte_q <= chr;
      okind_q <= kind;
      opair_q <= pair;
      olen_q  <= is_len;
      oerr_q  <= err_d;
      odone_q <= (ph_d == PH_DONE);
      ocl_q   <= cl;
    end
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tdata_o  = {4'd0, ocl_q, odone_q, oerr_q, olen_q, opair_q, obyte_q};

  a_len_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && olen_q) |-> opair_q)
    else $error("length header flagged without a completed pair");

  a_pair_is_delim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && opair_q) |-> (okind_q == KIND_DELIM))
    else $error("pair completion on a non-delimiter byte");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && !(take && q_rdata_i.restart)) |=> err_q)
    else $error("error flag dropped without restart");

  a_err_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q == (ph_q == PH_ERROR))
    else $error("error flag and error phase disagree");

endmodule

`default_nettype wire

### hdl/http_request_byte_parser_top.sv
// http_request_byte_parser_top: http/1.1 request byte parser, one byte per transfer
// instantiates hrbp_front, hrbp_queue and hrbp_back; uses hrbp_pkg
//
// channel   dir  tdata                                   tuser
// s_axis    in   [7:0] byte_in                           [0] restart
// m_axis    out  [7:0] byte_out, [8] pair_complete,      [2:0] field_kind
//                [9] length_header, [10] parse_error,
//                [11] request_done, [43:12] content_length, [47:44] zero
//
// sustains one byte per cycle while the output is not stalled: the state update and the x10
// accumulate of the value converter both sit in the combinational logic of the back end
// an accepted byte is written into the queue at its transfer edge, and its result is then
// registered in the output register when the back end takes the byte from the queue
// reset clears all control state at once; no clearing pass is needed
// a two-entry queue lets the front keep taking bytes while the output is stalled;
// input ready drops only when the queue is full
`default_nettype none

module http_request_byte_parser_top
  import hrbp_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] byte_in
  input  wire logic [0:0]  s_axis_tuser_i,  // [0] restart
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,  // byte_out, pair_complete, length_header,
                                            // parse_error, request_done, content_length
  output logic [2:0]       m_axis_tuser_o   // [2:0] field_kind
);

  // front to queue
  logic q_push;
  cls_t q_wdata;
  logic q_full;

  // queue to back
  logic q_pop;
  cls_t q_rdata;
  logic q_not_empty;

  // classifies each byte as it is accepted
  hrbp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_wdata_o       (q_wdata)
  );

  // decouples the front from output stalls
  hrbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .wdata_i     (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .rdata_o     (q_rdata),
    .not_empty_o (q_not_empty)
  );

  // request state machine, length conversion and body count
  hrbp_back #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_not_empty_i   (q_not_empty),
    .q_rdata_i       (q_rdata),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

### tb/http_request_byte_parser_top_test.sv
// http_request_byte_parser_top_test: self-checking bench for the http request byte parser
// streams directed and random request bytes, predicts each tagged result and checks it
// depends on hrbp_pkg and http_request_byte_parser_top
`timescale 1ns / 1ps

module http_request_byte_parser_top_test;
  import hrbp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 310;

  // "Content-Length", first character in the top byte
  localparam logic [8*14-1:0] LENGTH_NAME = "Content-Length";
  localparam logic [31:0]     LEN_MAX     = 32'hffff_ffff;

  typedef enum logic [3:0] {
    ST_METHOD, ST_URI, ST_VERSION, ST_LINE_LF, ST_NAME, ST_SPACE,
    ST_VALUE, ST_PAIR_LF, ST_HDRS_LF, ST_BODY, ST_DONE, ST_ERROR
  } parse_state_e;

  typedef enum logic [1:0] {CV_SKIP, CV_SIGN, CV_DIGITS, CV_STOP} conv_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } req_byte_t;

  typedef struct packed {
    logic [7:0]  data;
    kind_e       kind;
    logic        pair;
    logic        is_len;
    logic        err;
    logic        done;
    logic [31:0] clen;
  } parse_result_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data  = 8'h00;
  logic [0:0]  s_user  = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;
  logic [2:0]  m_user;

  http_request_byte_parser_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // bytes waiting to be sent, and tagged results waiting to come back
  req_byte_t     request_bytes[$];
  parse_result_t pending_tags[$];

  int gap_pct     = 0;
  int stall_pct   = 0;
  int error_count = 0;
  int result_idx  = 0;
  int cycle_count = 0;

  // parser state as predicted
  parse_state_e parse_state;
  conv_state_e  conv_state;
  logic [3:0]   name_pos;
  logic         name_miss;
  logic [31:0]  conv_acc;
  logic         conv_neg;
  logic         have_length;
  logic [31:0]  body_len;
  logic [31:0]  body_cnt;
  logic         fault_flag;

  task automatic clear_pair();
    name_pos   = '0;
    name_miss  = 1'b0;
    conv_acc   = '0;
    conv_state = CV_SKIP;
    conv_neg   = 1'b0;
  endtask

  task automatic clear_parser();
    parse_state = ST_METHOD;
    clear_pair();
    have_length = 1'b0;
    body_len    = '0;
    body_cnt    = '0;
    fault_flag  = 1'b0;
  endtask

  // advance the predicted parser by one byte and queue the tagged result
  task automatic classify_byte(input logic [7:0] c, input logic restart);
    parse_result_t r;
    logic [31:0]   d;
    r.data   = c;
    r.kind   = KIND_DELIM;
    r.pair   = 1'b0;
    r.is_len = 1'b0;
    if (restart) clear_parser();
    case (parse_state)
      ST_METHOD: begin
        if (c == CHR_SPACE) parse_state = ST_URI;
        else r.kind = KIND_METHOD;
      end
      ST_URI: begin
        if (c == CHR_SPACE) parse_state = ST_VERSION;
        else r.kind = KIND_URI;
      end
      ST_VERSION: begin
        if (c == CHR_CR) parse_state = ST_LINE_LF;
        else r.kind = KIND_VERSION;
      end
      ST_LINE_LF: begin
        if (c == CHR_LF) parse_state = ST_NAME;
        else begin
          fault_flag  = 1'b1;
          parse_state = ST_ERROR;
        end
      end
      ST_NAME: begin
        if (c == CHR_COLON) parse_state = ST_SPACE;
        else if (c == CHR_CR) parse_state = ST_HDRS_LF;
        else begin
          r.kind = KIND_NAME;
          // exact, case-sensitive match; anything past 14 characters spoils it
          if (name_miss || name_pos >= NAME_LEN) name_miss = 1'b1;
          else if (LENGTH_NAME[8*(13-int'(name_pos)) +: 8] == c) name_pos = name_pos + 1'b1;
          else name_miss = 1'b1;
        end
      end
      ST_SPACE: begin
        if (c == CHR_SPACE) parse_state = ST_VALUE;
        else begin
          fault_flag  = 1'b1;
          parse_state = ST_ERROR;
        end
      end
      ST_VALUE: begin
        if (c == CHR_CR) parse_state = ST_PAIR_LF;
        else begin
          r.kind = KIND_VALUE;
          // atoi-style conversion, saturating
          if (conv_state == CV_STOP) begin
          end else if (conv_state == CV_SKIP && (c == CHR_SPACE || c == CHR_TAB ||
                       c == CHR_LF || c == CHR_VT || c == CHR_FF || c == CHR_CR)) begin
          end else if (conv_state == CV_SKIP && (c == CHR_PLUS || c == CHR_MINUS)) begin
            conv_neg   = (c == CHR_MINUS);
            conv_state = CV_SIGN;
          end else if (c >= CHR_ZERO && c <= CHR_NINE) begin
            d = {24'd0, c - CHR_ZERO};
            if (conv_acc > (LEN_MAX - d) / 32'd10) conv_acc = LEN_MAX;
            else conv_acc = conv_acc * 32'd10 + d;
            conv_state = CV_DIGITS;
          end else begin
            conv_state = CV_STOP;
          end
        end
      end
      ST_PAIR_LF: begin
        if (c != CHR_LF) begin
          fault_flag  = 1'b1;
          parse_state = ST_ERROR;
        end else begin
          r.pair = 1'b1;
          if (!name_miss && name_pos == NAME_LEN) begin
            r.is_len    = 1'b1;
            have_length = 1'b1;
            body_len    = (conv_neg && conv_acc != '0) ? LEN_MAX : conv_acc;
          end
          clear_pair();
          parse_state = ST_NAME;
        end
      end
      ST_HDRS_LF: begin
        if (c != CHR_LF) begin
          fault_flag  = 1'b1;
          parse_state = ST_ERROR;
        end else begin
          body_cnt    = '0;
          parse_state = (have_length && body_len != '0) ? ST_BODY : ST_DONE;
        end
      end
      ST_BODY: begin
        r.kind   = KIND_BODY;
        body_cnt = body_cnt + 32'd1;
        if (body_cnt == body_len) parse_state = ST_DONE;
      end
      default: begin
      end
    endcase
    r.err  = fault_flag;
    r.done = (parse_state == ST_DONE);
    r.clen = body_len;
    pending_tags.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("result %0d: %s got %0h, expected %0h", result_idx, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] b, input logic restart);
    req_byte_t e;
    e.data    = b;
    e.restart = restart;
    request_bytes.push_back(e);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_byte(input logic [7:0] not_a, input logic [7:0] not_b);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == not_a || b == not_b) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic add_noise(input int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
  endtask

  // header value text; val is the length it should convert to
  task automatic add_value(output logic [31:0] val);
    int n;
    n   = $urandom_range(0, 6);
    val = n;
    case ($urandom_range(0, 11))
      0: add_text($sformatf("%0d", n));
      1: add_text($sformatf("+%0d", n));
      2: begin
        // leading whitespace of every kind the converter skips, but CR, which ends the value
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 4))
            0:       add_byte(CHR_SPACE, 1'b0);
            1:       add_byte(CHR_TAB, 1'b0);
            2:       add_byte(CHR_LF, 1'b0);
            3:       add_byte(CHR_VT, 1'b0);
            default: add_byte(CHR_FF, 1'b0);
          endcase
        end
        add_text($sformatf("%0d", n));
      end
      3: begin
        if ($urandom_range(0, 1) == 0) add_text("-0");
        else add_text("-000");
        val = '0;
      end
      4: begin
        add_text($sformatf("-%0d", n + 1));
        val = LEN_MAX;
      end
      5: begin
        add_text($sformatf("%0d%09d", $urandom_range(5, 999), $urandom_range(0, 999999999)));
        val = LEN_MAX;
      end
      6: begin
        if ($urandom_range(0, 1) == 0) add_text("4294967295");
        else add_text("4294967296");
        val = LEN_MAX;
      end
      7: begin
        // digits stop at the first other byte
        add_text($sformatf("%0d", n));
        add_byte(8'($urandom_range(65, 90)), 1'b0);
        repeat ($urandom_range(0, 3)) add_byte(pick_byte(CHR_CR, CHR_CR), 1'b0);
      end
      8: val = '0;
      9: begin
        add_byte(8'($urandom_range(65, 90)), 1'b0);
        add_text($sformatf("%0d", n));
        val = '0;
      end
      10: add_text($sformatf("00%0d", n));
      default: begin
        if ($urandom_range(0, 1) == 0) add_text("+-5");
        else add_text("- 5");
        val = '0;
      end
    endcase
  endtask

  // one request; broken picks a framing byte to spoil:
  // 1 request line LF, 2 space after the colon, 3 pair LF, 4 header end LF
  task automatic add_request(input int broken);
    int          n_hdr;
    logic [31:0] len_val;
    logic [31:0] v;
    bit          is_len;
    add_byte(8'($urandom_range(65, 90)), 1'b1);
    repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(65, 90)), 1'b0);
    add_byte(CHR_SPACE, 1'b0);
    repeat ($urandom_range(1, 8)) add_byte(pick_byte(CHR_SPACE, CHR_SPACE), 1'b0);
    add_byte(CHR_SPACE, 1'b0);
    if ($urandom_range(0, 3) != 0) add_text("HTTP/1.1");
    else repeat ($urandom_range(0, 6)) add_byte(pick_byte(CHR_CR, CHR_CR), 1'b0);
    add_byte(CHR_CR, 1'b0);
    if (broken == 1) begin
      add_byte(pick_byte(CHR_LF, CHR_LF), 1'b0);
      add_noise($urandom_range(1, 4));
      return;
    end
    add_byte(CHR_LF, 1'b0);

    len_val = '0;
    n_hdr   = $urandom_range(0, 4);
    for (int h = 0; h < n_hdr; h++) begin
      is_len = 1'b0;
      case ($urandom_range(0, 6))
        0, 1, 2: begin
          add_text("Content-Length");
          is_len = 1'b1;
        end
        3: add_text("content-length");
        4: add_text("Content-Lengthx");
        5: add_text("Content-Len");
        default: repeat ($urandom_range(1, 10)) add_byte(pick_byte(CHR_COLON, CHR_CR), 1'b0);
      endcase
      add_byte(CHR_COLON, 1'b0);
      if (broken == 2 && h == 0) begin
        add_byte(pick_byte(CHR_SPACE, CHR_SPACE), 1'b0);
        add_noise($urandom_range(1, 4));
        return;
      end
      add_byte(CHR_SPACE, 1'b0);
      add_value(v);
      if (is_len) len_val = v;   // the last one wins
      add_byte(CHR_CR, 1'b0);
      if (broken == 3 && h == 0) begin
        add_byte(pick_byte(CHR_LF, CHR_LF), 1'b0);
        add_noise($urandom_range(1, 4));
        return;
      end
      add_byte(CHR_LF, 1'b0);
    end

    add_byte(CHR_CR, 1'b0);
    if (broken == 4) begin
      add_byte(pick_byte(CHR_LF, CHR_LF), 1'b0);
      add_noise($urandom_range(1, 4));
      return;
    end
    add_byte(CHR_LF, 1'b0);

    // a saturated length never completes, so send a few body bytes and move on
    if (len_val <= 32'd16) repeat (len_val) add_byte(8'($urandom_range(0, 255)), 1'b0);
    else repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)), 1'b0);
    if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 3));
  endtask

  task automatic wait_idle();
    while (request_bytes.size() != 0 || s_valid || pending_tags.size() != 0)
      @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued bytes, predicts each one at its transfer
  // ---------------------------------------------------------------------------

  req_byte_t next_byte;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) classify_byte(s_data, s_user[0]);
      if (!s_valid || s_ready) begin
        if (request_bytes.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          next_byte = request_bytes.pop_front();
          s_valid   <= 1'b1;
          s_data    <= next_byte.data;
          s_user    <= next_byte.restart;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every result transfer against the oldest prediction
  // ---------------------------------------------------------------------------

  parse_result_t want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        if (pending_tags.size() == 0) begin
          report_mismatch("unexpected result, byte_out", {24'd0, m_data[7:0]}, '0);
        end else begin
          want = pending_tags.pop_front();
          if (m_data[7:0] !== want.data)
            report_mismatch("byte_out", {24'd0, m_data[7:0]}, {24'd0, want.data});
          if (m_user !== want.kind)
            report_mismatch("field_kind", {29'd0, m_user}, {29'd0, want.kind});
          if (m_data[8] !== want.pair)
            report_mismatch("pair_complete", {31'd0, m_data[8]}, {31'd0, want.pair});
          if (m_data[9] !== want.is_len)
            report_mismatch("length_header", {31'd0, m_data[9]}, {31'd0, want.is_len});
          if (m_data[10] !== want.err)
            report_mismatch("parse_error", {31'd0, m_data[10]}, {31'd0, want.err});
          if (m_data[11] !== want.done)
            report_mismatch("request_done", {31'd0, m_data[11]}, {31'd0, want.done});
          if (m_data[43:12] !== want.clen)
            report_mismatch("content_length", m_data[43:12], want.clen);
          if (m_data[47:44] !== 4'd0)
            report_mismatch("tdata padding", {28'd0, m_data[47:44]}, '0);
        end
        result_idx++;
      end
      m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_tags.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, directed bytes, then random traffic in four idling phases
  // ---------------------------------------------------------------------------

  initial begin
    clear_parser();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // byte extremes in the request line, a plain header, empty header end
    add_byte(8'h00, 1'b1);
    add_byte(8'hff, 1'b0);
    add_byte(CHR_SPACE, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(CHR_SPACE, 1'b0);
    add_byte(8'h7f, 1'b0);
    add_byte(CHR_CR, 1'b0);
    add_byte(CHR_LF, 1'b0);
    add_text("X: -5");
    add_byte(CHR_CR, 1'b0);
    add_byte(CHR_LF, 1'b0);
    add_byte(CHR_CR, 1'b0);
    add_byte(CHR_LF, 1'b0);
    // ignored once done
    add_byte(8'hff, 1'b0);
    // missing LF after the request line, then a byte in the error state
    add_byte(CHR_SPACE, 1'b1);
    add_byte(CHR_SPACE, 1'b0);
    add_byte(CHR_CR, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(CHR_LF, 1'b0);
    // no space after the colon of an empty name
    add_byte(8'h61, 1'b1);
    add_byte(CHR_SPACE, 1'b0);
    add_byte(CHR_SPACE, 1'b0);
    add_byte(CHR_CR, 1'b0);
    add_byte(CHR_LF, 1'b0);
    add_byte(CHR_COLON, 1'b0);
    add_byte(8'h62, 1'b0);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 48; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 48; end
        default: begin gap_pct = 21; stall_pct = 21; end
      endcase
      // mostly well-formed requests, some spoiled framing, some raw noise
      while (request_bytes.size() < PHASE_BYTES) begin
        if ($urandom_range(0, 9) == 0) add_noise($urandom_range(5, 20));
        else if ($urandom_range(0, 9) < 2) add_request($urandom_range(1, 4));
        else add_request(0);
      end
      // sender holds off until every result of the phase is back
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
